// ===== sv/llr_pkg.sv =====
// Shared types and constants for the light level linearizer.
// No dependencies; compile first.
package llr_pkg;

  localparam int unsigned LUX_W       = 16;
  localparam int unsigned ADC_W       = 8;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned SEG_COUNT   = 15;
  localparam int unsigned SEG_W       = $clog2(SEG_COUNT);
  localparam int unsigned DIVIDEND_W  = 16;
  localparam int unsigned DIVISOR_W   = 5;
  localparam int unsigned MANT_W      = 11;

  localparam logic [LUX_W-1:0]  EXP6_BITS = 16'h3000;
  localparam logic [MANT_W-1:0] MANT_MAX  = '1;
  localparam logic [LUX_W-1:0]  LUX_MAX   = '1;
  localparam logic [ADC_W-1:0]  BASE_LUX  = 8'd8;

  // Segment edges of the logarithmic table (upper ADC byte).
  localparam logic [ADC_W-1:0] SEG_EDGE [SEG_COUNT] = '{
    8'd0, 8'd1, 8'd12, 8'd24, 8'd35, 8'd47, 8'd59, 8'd71,
    8'd82, 8'd94, 8'd106, 8'd118, 8'd129, 8'd141, 8'd153
  };

  // Change modes
  localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PCT5 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PCT10 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PCT20 = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } llr_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Threshold divisor for a change mode; unused when sending is off.
  function automatic logic [DIVISOR_W-1:0] thr_divisor(input logic [MODE_W-1:0] mode);
    logic [DIVISOR_W-1:0] d;
    unique case (mode)
      MODE_OFF:   d = DIVISOR_W'(1);
      MODE_PCT5:  d = DIVISOR_W'(20);
      MODE_PCT10: d = DIVISOR_W'(10);
      MODE_PCT20: d = DIVISOR_W'(5);
      default:    d = DIVISOR_W'(3);
    endcase
    return d;
  endfunction

endpackage

// ===== sv/llr_in_if.sv =====
// Sample channel: valid/ready plus the two ADC bytes.
// Depends on llr_pkg.
interface llr_in_if;
  logic                     valid;
  logic                     ready;
  logic [llr_pkg::ADC_W-1:0] adc_high;
  logic [llr_pkg::ADC_W-1:0] adc_low;

  modport source (output valid, adc_high, adc_low, input ready);
  modport sink   (input valid, adc_high, adc_low, output ready);
endinterface

// ===== sv/llr_out_if.sv =====
// Result channel: valid/ready plus lux value, bus float word and flags.
// Depends on llr_pkg.
interface llr_out_if;
  logic                     valid;
  logic                     ready;
  logic [llr_pkg::LUX_W-1:0] lux_value;
  logic [llr_pkg::LUX_W-1:0] lux_word;
  logic                     value_changed;
  logic                     send_now;

  modport source (output valid, lux_value, lux_word, value_changed, send_now, input ready);
  modport sink   (input valid, lux_value, lux_word, value_changed, send_now, output ready);
endinterface

// ===== sv/llr_cfg_if.sv =====
// Configuration write channel carrying the change mode.
// Depends on llr_pkg.
interface llr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [llr_pkg::MODE_W-1:0] change_mode;

  modport source (output valid, change_mode, input ready);
  modport sink   (input valid, change_mode, output ready);
endinterface

// ===== sv/light_level_linearize_and_report.sv =====
// Top level of the light level linearizer and change reporter.
// Depends on llr_pkg, llr_in_if, llr_out_if, llr_cfg_if, llr_serdiv.
//
// Usage:
//   sample  - sink channel; one request carries adc_high/adc_low of one
//             light sensor conversion.
//   result  - source channel; one request per sample with lux_value,
//             lux_word (exponent 6 bus float), value_changed, send_now.
//   cfg     - write channel for change_mode; always ready. Write it only
//             while no sample is in flight.
// Timing: a sample is taken only in the idle state. Three bit-serial
//   dividers (interpolation of the upper byte, of the lower byte, and the
//   change threshold) run side by side, one quotient bit per cycle;
//   that serial loop sets the rate. The result register loads from the
//   final state once it is free, which raises result.valid; a new sample
//   can be taken only after the block has returned to idle.
// Stall: the result register holds its request until result.ready. A new
//   sample can be accepted and computed while it waits; the block then
//   holds in its final state until the register drains.
// Reset (rst, synchronous): back to idle, result channel empty, change
//   mode off and last sent lux value zero.
module light_level_linearize_and_report (
  input logic      clk,
  input logic      rst,
  llr_in_if.sink   sample,
  llr_out_if.source result,
  llr_cfg_if.sink  cfg
);
  import llr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);
  localparam logic [SEG_W-1:0] SEG_TOP  = SEG_W'(SEG_COUNT - 1);
  localparam logic [SEG_W-1:0] SEG_FINE = SEG_W'(7);
  localparam logic [SEG_W-1:0] SEG_INTERP = SEG_W'(11);

  // ---------------- configuration ----------------
  logic [MODE_W-1:0] change_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      change_mode <= MODE_OFF;
    end else if (cfg.valid) begin
      change_mode <= cfg.change_mode;
    end
  end

  // ---------------- control ----------------
  llr_state_t       state, state_next;
  div_ctrl_t        div_ctrl;
  logic [CNT_W-1:0] cnt;
  logic             out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    sample.ready  = 1'b0;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          div_ctrl.load = 1'b1;
          state_next    = ST_RUN;
        end
      end
      ST_RUN: begin
        div_ctrl.step = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        out_load = !result.valid || result.ready;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (div_ctrl.load) begin
      cnt <= '0;
    end else if (div_ctrl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // ---------------- segment search ----------------
  // Edges rise monotonically, so the segment is the count of edges at or
  // below the upper byte, clamped at the last segment.
  logic [SEG_W-1:0]      seg;
  logic [SEG_W-1:0]      seg_reg;
  logic [ADC_W-1:0]      rest;
  logic [DIVISOR_W-1:0]  seg_width;
  logic [DIVIDEND_W-1:0] coarse_dividend;
  logic [DIVIDEND_W-1:0] fine_dividend;
  logic [SEG_W-1:0]      shift;

  always_comb begin
    seg = '0;
    for (int k = 0; k < SEG_COUNT - 1; k++) begin
      seg = seg + SEG_W'(sample.adc_high >= SEG_EDGE[k]);
    end
  end

  always_comb begin
    rest      = sample.adc_high - SEG_EDGE[seg - 1'b1];
    seg_width = DIVISOR_W'(SEG_EDGE[seg] - SEG_EDGE[seg - 1'b1]);
    shift     = seg + SEG_W'(2);
    coarse_dividend = (seg < SEG_INTERP) ? (DIVIDEND_W'(rest) << shift) : '0;
    fine_dividend   = (seg < SEG_FINE) ? (DIVIDEND_W'(sample.adc_low) << shift) : '0;
  end

  always_ff @(posedge clk) begin
    if (div_ctrl.load) begin
      seg_reg <= seg;
    end
  end

  // ---------------- serial dividers ----------------
  logic [LUX_W-1:0]      last_sent_lux;
  logic [DIVIDEND_W-1:0] coarse_q, fine_q, thr_q;

  llr_serdiv #(.DIVIDEND_W(DIVIDEND_W), .DIVISOR_W(DIVISOR_W)) u_div_coarse (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (coarse_dividend),
    .divisor  (seg_width),
    .quotient (coarse_q)
  );

  llr_serdiv #(.DIVIDEND_W(DIVIDEND_W), .DIVISOR_W(DIVISOR_W)) u_div_fine (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (fine_dividend),
    .divisor  (seg_width),
    .quotient (fine_q)
  );

  // last_sent_lux stays put while a sample is in flight; change_mode must also, but the block does not enforce it
  llr_serdiv #(.DIVIDEND_W(DIVIDEND_W), .DIVISOR_W(DIVISOR_W)) u_div_thr (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (DIVIDEND_W'(last_sent_lux)),
    .divisor  (thr_divisor(change_mode)),
    .quotient (thr_q)
  );

  // ---------------- assemble result ----------------
  logic [LUX_W:0]   base;
  logic [LUX_W:0]   lux_sum;
  logic [LUX_W-1:0] lux;
  logic [LUX_W+1:0] mant_sum;
  logic [MANT_W-1:0] mant;
  logic [LUX_W:0]   thr;
  logic             send_calc;

  always_comb begin
    base    = (seg_reg > SEG_W'(1)) ? ((LUX_W+1)'(BASE_LUX) << (seg_reg - 1'b1)) : '0;
    lux_sum = base + (LUX_W+1)'(coarse_q) + (LUX_W+1)'(fine_q[DIVIDEND_W-1:8]);
    lux     = lux_sum[LUX_W] ? LUX_MAX : lux_sum[LUX_W-1:0];

    mant_sum = (LUX_W+2)'(lux) + (LUX_W+2)'(lux >> 1) + (LUX_W+2)'(lux >> 4);
    mant     = (mant_sum > (LUX_W+2)'(MANT_MAX)) ? MANT_MAX : mant_sum[MANT_W-1:0];

    thr = (thr_q == '0) ? (LUX_W+1)'(1) : (LUX_W+1)'(thr_q);
    send_calc = (change_mode != MODE_OFF) &&
                (((LUX_W+1)'(lux) + thr <= (LUX_W+1)'(last_sent_lux)) ||
                 ((LUX_W+1)'(last_sent_lux) + thr <= (LUX_W+1)'(lux)));
  end

  // ---------------- result register and last sent value ----------------
  logic             out_valid;
  logic [LUX_W-1:0] out_lux, out_word;
  logic             out_changed, out_send;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_sent_lux <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        if (send_calc) begin
          last_sent_lux <= lux;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lux     <= lux;
      out_word    <= EXP6_BITS + LUX_W'(mant);
      out_changed <= (lux != last_sent_lux);
      out_send    <= send_calc;
    end
  end

  assign result.valid         = out_valid;
  assign result.lux_value     = out_lux;
  assign result.lux_word      = out_word;
  assign result.value_changed = out_changed;
  assign result.send_now      = out_send;

  // ---------------- assertions ----------------
  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> result.valid)
    else $error("result register not valid after load");

  a_send_implies_change: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.send_now |-> result.value_changed)
    else $error("send without a changed value");

  a_last_only_on_send: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (last_sent_lux != $past(last_sent_lux)) |-> $past(out_load && send_calc))
    else $error("last sent value moved without a send");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.step |-> !sample.ready)
    else $error("sample taken while dividers run");

endmodule

// ===== sv/llr_serdiv.sv =====
// Bit-serial restoring divider: one quotient bit per step.
// Depends on llr_pkg (control struct, default widths).
module llr_serdiv #(
  parameter int unsigned DIVIDEND_W = llr_pkg::DIVIDEND_W,
  parameter int unsigned DIVISOR_W  = llr_pkg::DIVISOR_W
) (
  input  logic                  clk,
  input  llr_pkg::div_ctrl_t    ctrl,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient
);
  import llr_pkg::*;

  logic [DIVIDEND_W-1:0] dq;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dv;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem, dq[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dq  <= dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (ctrl.step) begin
      // shift in the next dividend bit, subtract when it fits
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, dv});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      dq <= {dq[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule
